### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off during reset
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, ante, cons)
`define ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### src/i2a_pkg.sv
// ----------------------------------------------------------------------------
// i2a_pkg
// types and constants of the integer to ascii converter
// ----------------------------------------------------------------------------
package i2a_pkg;

  localparam int NDIG     = 9;
  localparam int DIG_W    = NDIG * 4;
  localparam int DAB_BITS = 30;

  localparam logic [2:0] OP_SDEC       = 3'd0;
  localparam logic [2:0] OP_SDEC_FORCE = 3'd1;
  localparam logic [2:0] OP_UDEC       = 3'd2;
  localparam logic [2:0] OP_SHEX       = 3'd3;
  localparam logic [2:0] OP_UHEX       = 3'd4;

  localparam logic [31:0] SDEC_LIMIT = 32'h05F5_E0FF;
  localparam logic [31:0] UDEC_LIMIT = 32'h3B9A_C9FE;
  localparam logic [31:0] MIN_SIGNED = 32'h8000_0000;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ALPHA = 8'h37;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_NONE  = 8'h00;

  typedef struct packed {
    logic [31:0] value;
    logic [2:0]  operation;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
    logic       overflow;
  } out_beat_t;

  typedef struct packed {
    logic busy;
    logic done;
  } dab_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_DIGIT,
    ST_OVF
  } state_t;

endpackage

### src/integer_to_ascii_decimal_hex.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_decimal_hex
// 32-bit word to ascii text, signed/unsigned decimal or hex, one char per beat
// ----------------------------------------------------------------------------
// decimal: the bcd unit converts the magnitude, then leading zeros are skipped and the
//   sign and digit beats follow; the next input beat is taken once the last char beat is out
// hex: no bcd unit, leading zeros are skipped, then the sign and digit beats follow
// overflow: a lone beat, no bcd unit
// zero skip plus characters always cover all nine digits; out_stall holds every char beat
// rst_n synchronous active low clears sequencer, counters and out_valid
module integer_to_ascii_decimal_hex (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  i2a_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output i2a_pkg::out_beat_t out_data
);

`include "assert_macros.svh"

  i2a_pkg::state_t state_r, state_nxt;

  // working registers
  logic [i2a_pkg::DIG_W-1:0] digits_r, digits_nxt;  // digit nibbles, msd at top
  logic [3:0]                cnt_r, cnt_nxt;        // digits still in digits_r
  logic [7:0]                prefix_r, prefix_nxt;  // sign char or none
  logic                      hex_r, hex_nxt;

  // output register
  logic                      out_valid_r, out_valid_nxt;
  i2a_pkg::out_beat_t        out_data_r, out_data_nxt;

  // decode of the incoming word
  logic        in_acc;
  logic        op_signed, op_hex, op_ok, neg, ovf;
  logic [31:0] mag;
  logic [2:0]  op;

  // bcd unit, used by the decimal formats only
  logic                      dab_start;
  i2a_pkg::dab_stat_t        dab_st;
  logic [i2a_pkg::DIG_W-1:0] dab_bcd;

  // emitter helpers
  logic       slot_free;
  logic [3:0] top_nib;
  logic [7:0] dig_char;
  logic       skip_more;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != i2a_pkg::ST_IDLE);
  assign slot_free = !out_valid_r || !out_stall;

  assign op        = in_data.operation;
  assign op_signed = (op == i2a_pkg::OP_SDEC) || (op == i2a_pkg::OP_SDEC_FORCE) ||
                     (op == i2a_pkg::OP_SHEX);
  assign op_hex    = (op == i2a_pkg::OP_SHEX) || (op == i2a_pkg::OP_UHEX);
  assign op_ok     = op_signed || (op == i2a_pkg::OP_UDEC) || (op == i2a_pkg::OP_UHEX);
  assign neg       = op_signed && in_data.value[31];
  assign mag       = neg ? (32'd0 - in_data.value) : in_data.value;

  // decimal range limits and the unrepresentable most negative word
  always_comb begin
    case (op)
      i2a_pkg::OP_SDEC, i2a_pkg::OP_SDEC_FORCE:
        ovf = (in_data.value == i2a_pkg::MIN_SIGNED) || (mag > i2a_pkg::SDEC_LIMIT);
      i2a_pkg::OP_SHEX:
        ovf = (in_data.value == i2a_pkg::MIN_SIGNED);
      i2a_pkg::OP_UDEC:
        ovf = (in_data.value > i2a_pkg::UDEC_LIMIT);
      default:
        ovf = 1'b0;
    endcase
  end

  assign dab_start = in_acc && op_ok && !ovf && !op_hex;

  i2a_dabble u_dabble (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dab_start),
    .bin   (mag[i2a_pkg::DAB_BITS-1:0]),
    .stat  (dab_st),
    .bcd   (dab_bcd)
  );

  assign top_nib   = digits_r[i2a_pkg::DIG_W-1 -: 4];
  assign dig_char  = (top_nib >= 4'd10) ? ({4'h0, top_nib} + i2a_pkg::CH_ALPHA)
                                        : ({4'h0, top_nib} + i2a_pkg::CH_ZERO);
  // drop leading zeros but always keep one digit
  assign skip_more = (top_nib == 4'h0) && (cnt_r > 4'd1);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      i2a_pkg::ST_IDLE: begin
        if (in_acc && op_ok) begin
          if (ovf)         state_nxt = i2a_pkg::ST_OVF;
          else if (op_hex) state_nxt = i2a_pkg::ST_SKIP;
          else             state_nxt = i2a_pkg::ST_CONV;
        end
      end
      i2a_pkg::ST_CONV: begin
        if (dab_st.done) state_nxt = i2a_pkg::ST_SKIP;
      end
      i2a_pkg::ST_SKIP: begin
        if (!skip_more) begin
          state_nxt = (prefix_r != i2a_pkg::CH_NONE) ? i2a_pkg::ST_SIGN
                                                     : i2a_pkg::ST_DIGIT;
        end
      end
      i2a_pkg::ST_SIGN: begin
        if (slot_free) state_nxt = i2a_pkg::ST_DIGIT;
      end
      i2a_pkg::ST_DIGIT: begin
        if (slot_free && (cnt_r == 4'd1)) state_nxt = i2a_pkg::ST_IDLE;
      end
      i2a_pkg::ST_OVF: begin
        if (slot_free) state_nxt = i2a_pkg::ST_IDLE;
      end
      default: state_nxt = i2a_pkg::ST_IDLE;
    endcase
  end

  // datapath and output beat
  always_comb begin
    digits_nxt    = digits_r;
    cnt_nxt       = cnt_r;
    prefix_nxt    = prefix_r;
    hex_nxt       = hex_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      i2a_pkg::ST_IDLE: begin
        if (in_acc) begin
          hex_nxt    = op_hex;
          cnt_nxt    = 4'(i2a_pkg::NDIG);
          digits_nxt = {4'h0, mag};
          if (neg)
            prefix_nxt = i2a_pkg::CH_MINUS;
          else if (op == i2a_pkg::OP_SDEC_FORCE)
            prefix_nxt = i2a_pkg::CH_PLUS;
          else
            prefix_nxt = i2a_pkg::CH_NONE;
        end
      end
      i2a_pkg::ST_CONV: begin
        if (dab_st.done) digits_nxt = dab_bcd;
      end
      i2a_pkg::ST_SKIP: begin
        if (skip_more) begin
          digits_nxt = {digits_r[i2a_pkg::DIG_W-5:0], 4'h0};
          cnt_nxt    = cnt_r - 4'd1;
        end
      end
      i2a_pkg::ST_SIGN: begin
        if (slot_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.char_code = prefix_r;
          out_data_nxt.last_char = 1'b0;
          out_data_nxt.overflow  = 1'b0;
        end
      end
      i2a_pkg::ST_DIGIT: begin
        if (slot_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.char_code = dig_char;
          out_data_nxt.last_char = (cnt_r == 4'd1);
          out_data_nxt.overflow  = 1'b0;
          digits_nxt             = {digits_r[i2a_pkg::DIG_W-5:0], 4'h0};
          cnt_nxt                = cnt_r - 4'd1;
        end
      end
      i2a_pkg::ST_OVF: begin
        if (slot_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.char_code = i2a_pkg::CH_NONE;
          out_data_nxt.last_char = 1'b1;
          out_data_nxt.overflow  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    digits_r   <= digits_nxt;
    prefix_r   <= prefix_nxt;
    hex_r      <= hex_nxt;
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      state_r     <= i2a_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // an overflow beat is always a lone zero character closing the run
  `ASSERT_IMP(a_ovf_beat, out_valid_r && out_data_r.overflow, out_data_r.last_char && (out_data_r.char_code == i2a_pkg::CH_NONE))
  // the bcd unit is running or finishing whenever the sequencer waits on it
  `ASSERT_IMP(a_conv_busy, state_r == i2a_pkg::ST_CONV, dab_st.busy || dab_st.done)
  // conversion only finishes while the sequencer waits on it
  `ASSERT_IMP(a_done_conv, dab_st.done, state_r == i2a_pkg::ST_CONV)
  // emitter never runs out of digits
  `ASSERT_IMP(a_digit_cnt, state_r == i2a_pkg::ST_DIGIT, (cnt_r != 4'd0) && (cnt_r <= 4'(i2a_pkg::NDIG)))
  // decimal digits stay in 0..9
  `ASSERT_IMP(a_dec_digit, (state_r == i2a_pkg::ST_DIGIT) && !hex_r, top_nib <= 4'd9)

endmodule

### src/i2a_dabble.sv
// ----------------------------------------------------------------------------
// i2a_dabble
// bit-serial binary to bcd unit, shift and add-3, one bit per cycle
// ----------------------------------------------------------------------------
module i2a_dabble (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [i2a_pkg::DAB_BITS-1:0] bin,
  output i2a_pkg::dab_stat_t          stat,
  output logic [i2a_pkg::DIG_W-1:0]   bcd
);

  logic [i2a_pkg::DAB_BITS-1:0] bin_r, bin_nxt;
  logic [i2a_pkg::DIG_W-1:0]    bcd_r, bcd_nxt;
  logic [4:0]                   cnt_r, cnt_nxt;
  logic                         done_r, done_nxt;
  logic [i2a_pkg::DIG_W-1:0]    adj;

  // add 3 to every digit of five or more
  always_comb begin
    for (int i = 0; i < i2a_pkg::NDIG; i++) begin
      adj[i*4 +: 4] = (bcd_r[i*4 +: 4] >= 4'd5) ? (bcd_r[i*4 +: 4] + 4'd3)
                                                 : bcd_r[i*4 +: 4];
    end
  end

  always_comb begin
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      bin_nxt = bin;
      bcd_nxt = '0;
      cnt_nxt = 5'(i2a_pkg::DAB_BITS);
    end else if (cnt_r != 5'd0) begin
      bcd_nxt  = {adj[i2a_pkg::DIG_W-2:0], bin_r[i2a_pkg::DAB_BITS-1]};
      bin_nxt  = {bin_r[i2a_pkg::DAB_BITS-2:0], 1'b0};
      cnt_nxt  = cnt_r - 5'd1;
      done_nxt = (cnt_r == 5'd1);
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  assign stat.busy = (cnt_r != 5'd0);
  assign stat.done = done_r;
  assign bcd       = bcd_r;

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the integer to ascii converter
// ----------------------------------------------------------------------------
// words go in with a random format. A model of the conversion predicts the
// character beats, and every output beat is checked against the oldest
// prediction. Directed corner words come first, then a few hundred random
// ones. Both handshakes idle at random, and one long receiver hold-off lets
// the block back up into its input.
// ----------------------------------------------------------------------------
module tb;

  // selector codes that the block ignores
  localparam logic [2:0] OP_RSV5 = 3'd5;
  localparam logic [2:0] OP_RSV6 = 3'd6;
  localparam logic [2:0] OP_RSV7 = 3'd7;

  localparam int RANDOM_WORDS  = 370;
  localparam int HOLD_AT_WORD  = 200;  // word count that starts the long hold-off
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 64;   // longest decimal conversion plus margin
  localparam int REPORT_LIMIT  = 10;

  typedef struct {
    i2a_pkg::in_beat_t beat;
    int unsigned       gap;   // idle cycles before this word is offered
  } pending_word_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  i2a_pkg::in_beat_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  i2a_pkg::out_beat_t out_data;

  pending_word_t      word_queue[$];     // words waiting to be driven
  i2a_pkg::out_beat_t expected_chars[$]; // predicted character beats, oldest first

  int unsigned words_accepted = 0;
  int unsigned chars_seen = 0;
  int unsigned mismatch_count = 0;
  int unsigned gap_count = 0;
  int unsigned stall_left = 0;
  int unsigned hold_cycles = 0;
  logic        hold_done = 1'b0;

  integer_to_ascii_decimal_hex dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ----------------------------------------------------------------------------
  // model of the conversion: pushes the character beats that one word yields
  // ----------------------------------------------------------------------------
  function automatic void predict_text(input i2a_pkg::in_beat_t w);
    logic [31:0]        mag;
    logic [31:0]        rem;
    logic [7:0]         sign_ch;
    logic [7:0]         digs[$];
    logic [31:0]        radix;
    logic               neg;
    logic               ovf;
    i2a_pkg::out_beat_t c;
    mag = w.value;
    neg = w.value[31];
    sign_ch = i2a_pkg::CH_NONE;
    radix = 32'd10;
    ovf = 1'b0;
    case (w.operation)
      i2a_pkg::OP_SDEC, i2a_pkg::OP_SDEC_FORCE, i2a_pkg::OP_SHEX: begin
        if (neg) begin
          mag = 32'd0 - w.value;
        end
        if (w.operation == i2a_pkg::OP_SHEX) begin
          radix = 32'd16;
        end
        // most negative word has no positive magnitude
        if (w.value == i2a_pkg::MIN_SIGNED) begin
          ovf = 1'b1;
        end else if (radix == 32'd10 && mag > i2a_pkg::SDEC_LIMIT) begin
          ovf = 1'b1;
        end
        if (neg) begin
          sign_ch = i2a_pkg::CH_MINUS;
        end else if (w.operation == i2a_pkg::OP_SDEC_FORCE) begin
          sign_ch = i2a_pkg::CH_PLUS;
        end
      end
      i2a_pkg::OP_UDEC: begin
        if (w.value > i2a_pkg::UDEC_LIMIT) begin
          ovf = 1'b1;
        end
      end
      i2a_pkg::OP_UHEX: begin
        radix = 32'd16;
      end
      default: begin
        return;  // ignored selector, no text at all
      end
    endcase
    if (ovf) begin
      c.char_code = i2a_pkg::CH_NONE;
      c.last_char = 1'b1;
      c.overflow  = 1'b1;
      expected_chars.push_back(c);
      return;
    end
    // digits least significant first, stored so the front is the top digit
    do begin
      rem = mag % radix;
      if (rem >= 32'd10) begin
        digs.push_front(i2a_pkg::CH_ALPHA + rem[7:0]);
      end else begin
        digs.push_front(i2a_pkg::CH_ZERO + rem[7:0]);
      end
      mag = mag / radix;
    end while (mag != 32'd0);
    if (sign_ch != i2a_pkg::CH_NONE) begin
      c.char_code = sign_ch;
      c.last_char = 1'b0;
      c.overflow  = 1'b0;
      expected_chars.push_back(c);
    end
    foreach (digs[i]) begin
      c.char_code = digs[i];
      c.last_char = (i == digs.size() - 1);
      c.overflow  = 1'b0;
      expected_chars.push_back(c);
    end
  endfunction

  // random word, weighted toward short strings and the limits
  function automatic i2a_pkg::in_beat_t random_word();
    i2a_pkg::in_beat_t w;
    int unsigned       kind;
    logic [31:0]       edge_val;
    kind = $urandom_range(0, 9);
    w.operation = 3'($urandom_range(0, 4));
    case (kind)
      0, 1, 2: w.value = $urandom;
      3, 4: w.value = $urandom_range(0, 999);
      5: begin
        case ($urandom_range(0, 4))
          0: edge_val = i2a_pkg::SDEC_LIMIT;
          1: edge_val = i2a_pkg::UDEC_LIMIT;
          2: edge_val = i2a_pkg::MIN_SIGNED;
          3: edge_val = 32'h7FFF_FFFF;
          default: edge_val = 32'h0000_0000;
        endcase
        w.value = edge_val + $urandom_range(0, 2) - 1;
      end
      6: w.value = $urandom >> $urandom_range(0, 31);
      7, 8: w.value = $urandom_range(0, i2a_pkg::SDEC_LIMIT);
      default: begin
        w.value = $urandom;
        w.operation = 3'($urandom_range(OP_RSV5, OP_RSV7));
      end
    endcase
    // small and mid magnitudes also show up negative
    if (kind >= 3 && kind <= 8 && $urandom_range(0, 2) == 0) begin
      w.value = 32'd0 - w.value;
    end
    return w;
  endfunction

  // ----------------------------------------------------------------------------
  // input driver: offers queued words, holds a beat while stalled
  // ----------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      in_data   <= '0;
      gap_count <= 0;
    end else if (!(in_valid && in_stall)) begin
      // beat taken at this edge: predict its text
      if (in_valid) begin
        predict_text(in_data);
        words_accepted <= words_accepted + 1;
      end
      if (word_queue.size() == 0) begin
        in_valid <= 1'b0;
      end else if (gap_count < word_queue[0].gap) begin
        in_valid  <= 1'b0;
        gap_count <= gap_count + 1;
      end else begin
        in_data   <= word_queue[0].beat;
        in_valid  <= 1'b1;
        gap_count <= 0;
        void'(word_queue.pop_front());
      end
    end
  end

  // ----------------------------------------------------------------------------
  // long receiver hold-off, once, so the block backs up into in_stall
  // ----------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cycles <= 0;
      hold_done   <= 1'b0;
    end else if (!hold_done && words_accepted >= HOLD_AT_WORD) begin
      hold_cycles <= HOLD_CYCLES;
      hold_done   <= 1'b1;
    end else if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  // ----------------------------------------------------------------------------
  // output monitor: random stall per beat, checks each taken beat
  // ----------------------------------------------------------------------------
  always @(posedge clk) begin
    int unsigned        nxt;
    i2a_pkg::out_beat_t want;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      nxt = stall_left;
      if (out_valid && !out_stall) begin
        chars_seen <= chars_seen + 1;
        if (expected_chars.size() == 0) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < REPORT_LIMIT) begin
            $display("%0t: unexpected char beat code=%02h last=%0b ovf=%0b",
                     $realtime, out_data.char_code, out_data.last_char,
                     out_data.overflow);
          end
        end else begin
          want = expected_chars.pop_front();
          if (out_data.char_code !== want.char_code ||
              out_data.last_char !== want.last_char ||
              out_data.overflow  !== want.overflow) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < REPORT_LIMIT) begin
              $display("%0t: char beat mismatch exp code=%02h last=%0b ovf=%0b",
                       $realtime, want.char_code, want.last_char, want.overflow);
              $display("%0t:                    got code=%02h last=%0b ovf=%0b",
                       $realtime, out_data.char_code, out_data.last_char,
                       out_data.overflow);
            end
          end
        end
        // every fourth window of 64 chars runs with no receiver stall
        if ((chars_seen / 64) % 4 == 1) begin
          nxt = 0;
        end else begin
          nxt = $urandom_range(0, 7);
        end
      end else if (nxt != 0) begin
        nxt = nxt - 1;
      end
      stall_left <= nxt;
      out_stall  <= (nxt != 0) || (hold_cycles != 0);
    end
  end

  // ----------------------------------------------------------------------------
  // stimulus and end of test
  // ----------------------------------------------------------------------------
  initial begin : stimulus
    pending_word_t     p;
    i2a_pkg::in_beat_t corner[$];
    i2a_pkg::in_beat_t w;
    int unsigned       n_valid;
    int unsigned       idx;

    // zero in every format, forced plus on zero
    w.value = 32'd0;
    for (int op = i2a_pkg::OP_SDEC; op <= i2a_pkg::OP_UHEX; op++) begin
      w.operation = 3'(op);
      corner.push_back(w);
    end
    corner.push_back('{value: 32'd1, operation: i2a_pkg::OP_SDEC});
    corner.push_back('{value: 32'd5, operation: i2a_pkg::OP_SDEC_FORCE});
    // forced sign on a negative word: a single minus
    corner.push_back('{value: 32'hFFFF_FFFF, operation: i2a_pkg::OP_SDEC_FORCE});
    // signed decimal limit, both sides and both signs
    corner.push_back('{value: i2a_pkg::SDEC_LIMIT, operation: i2a_pkg::OP_SDEC});
    corner.push_back('{value: i2a_pkg::SDEC_LIMIT + 32'd1, operation: i2a_pkg::OP_SDEC});
    corner.push_back('{value: 32'd0 - i2a_pkg::SDEC_LIMIT,
                       operation: i2a_pkg::OP_SDEC_FORCE});
    corner.push_back('{value: 32'hFA0A_1F00, operation: i2a_pkg::OP_SDEC});
    // most negative word in each signed format
    corner.push_back('{value: i2a_pkg::MIN_SIGNED, operation: i2a_pkg::OP_SDEC});
    corner.push_back('{value: i2a_pkg::MIN_SIGNED, operation: i2a_pkg::OP_SDEC_FORCE});
    corner.push_back('{value: i2a_pkg::MIN_SIGNED, operation: i2a_pkg::OP_SHEX});
    // unsigned decimal limit
    corner.push_back('{value: i2a_pkg::UDEC_LIMIT, operation: i2a_pkg::OP_UDEC});
    corner.push_back('{value: i2a_pkg::UDEC_LIMIT + 32'd1, operation: i2a_pkg::OP_UDEC});
    corner.push_back('{value: 32'hFFFF_FFFF, operation: i2a_pkg::OP_UDEC});
    // hex extremes, full width
    corner.push_back('{value: 32'hFFFF_FFFF, operation: i2a_pkg::OP_UHEX});
    corner.push_back('{value: 32'hFFFF_FFFF, operation: i2a_pkg::OP_SHEX});
    corner.push_back('{value: 32'h7FFF_FFFF, operation: i2a_pkg::OP_SHEX});
    corner.push_back('{value: 32'h7FFF_FFFF, operation: i2a_pkg::OP_SDEC});
    corner.push_back('{value: 32'hABCD_EF01, operation: i2a_pkg::OP_UHEX});
    // ignored selectors
    corner.push_back('{value: 32'h1234_5678, operation: OP_RSV5});
    corner.push_back('{value: 32'h0000_0007, operation: OP_RSV6});
    corner.push_back('{value: 32'hFFFF_FFFF, operation: OP_RSV7});

    foreach (corner[i]) begin
      p.beat = corner[i];
      p.gap  = $urandom_range(0, 7);
      word_queue.push_back(p);
    end

    // random words; ignored selectors do not count toward the total
    n_valid = 0;
    idx = 0;
    while (n_valid < RANDOM_WORDS) begin
      p.beat = random_word();
      // every third window of 40 words is sent back to back
      p.gap = ((idx / 40) % 3 == 1) ? 0 : $urandom_range(0, 7);
      word_queue.push_back(p);
      if (p.beat.operation <= i2a_pkg::OP_UHEX) begin
        n_valid++;
      end
      idx++;
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // all words taken, then all text back, then let the block settle
    while (word_queue.size() != 0 || in_valid) begin
      @(posedge clk);
    end
    while (expected_chars.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/i2a_pkg.sv
src/i2a_dabble.sv
src/integer_to_ascii_decimal_hex.sv
test/tb.sv
